// File: hdl/trm_pkg.sv
// Shared widths, codes and types of the two-channel RMS meter.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package trm_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int SUM_W      = 48;
  localparam int MULT_W     = 10;
  localparam int SDIV_W     = 8;
  localparam int MDIV_W     = 16;
  localparam int RMS_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int PROD_W = SAMPLE_W + MULT_W;
  localparam int SQ_W   = 2 * PROD_W;
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int X_W    = 2 * ROOT_W;
  localparam int ACC_W  = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;
  localparam int CNT_W  = $clog2(X_W);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUR_MULT = 3'd0,
    REG_CUR_DIV  = 3'd1,
    REG_VLT_MULT = 3'd2,
    REG_VLT_DIV  = 3'd3,
    REG_MEAN_DIV = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    L_IDLE,
    L_MUL,
    L_DIV,
    L_SQR,
    L_ACC,
    L_FDIV,
    L_ROOT,
    L_DONE
  } lane_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_RUN,
    T_HOLD
  } top_state_t;

  typedef struct packed {
    logic start;
    logic finish;
  } lane_cmd_t;

  typedef struct packed {
    logic             done;
    logic             sat;
    logic [RMS_W-1:0] rms;
  } lane_rsp_t;

endpackage

`default_nettype wire

// File: hdl/trm_lane.sv
// One measurement lane: scale, square and accumulate a reading; on finish,
// divide the sum by the mean divisor and take its floor square root.
// Depends on trm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trm_lane (
  input  wire                          clk,
  input  wire                          rst_n,
  input  trm_pkg::lane_cmd_t           cmd,
  input  wire [trm_pkg::SAMPLE_W-1:0]  sample,
  input  wire [trm_pkg::MULT_W-1:0]    mult,
  input  wire [trm_pkg::SDIV_W-1:0]    sdiv,
  input  wire [trm_pkg::MDIV_W-1:0]    mdiv,
  output trm_pkg::lane_rsp_t           rsp
);
  import trm_pkg::*;

  lane_state_t        state_r, state_nxt;
  logic [SUM_W-1:0]   sum_r;
  logic               sat_r;
  logic               sat_rep_r;
  logic [PROD_W-1:0]  prod_r;
  logic [X_W-1:0]     quo_r;
  logic [MDIV_W-1:0]  rem_r;
  logic [MDIV_W-1:0]  dvs_r;
  logic [SQ_W-1:0]    sq_r;
  logic [ROOT_W-1:0]  root_r;
  logic [ROOT_W:0]    srem_r;
  logic [CNT_W-1:0]   cnt_r;

  logic [SDIV_W-1:0]  sdiv_eff;
  logic [MDIV_W-1:0]  mdiv_eff;
  logic [MDIV_W:0]    dshift;
  logic [MDIV_W:0]    ddiff;
  logic               dge;
  logic [ROOT_W+2:0]  rshift;
  logic [ROOT_W+2:0]  rtrial;
  logic [ROOT_W+2:0]  rdiff;
  logic               rge;
  logic [PROD_W-1:0]  qv;
  logic [ACC_W-1:0]   acc_sum;
  logic               ovf;
  logic               last;

  // zero divisors pass the value undivided
  assign sdiv_eff = (sdiv == '0) ? SDIV_W'(1) : sdiv;
  assign mdiv_eff = (mdiv == '0) ? MDIV_W'(1) : mdiv;

  // restoring divide step
  assign dshift = {rem_r, quo_r[X_W-1]};
  assign ddiff  = dshift - {1'b0, dvs_r};
  assign dge    = (dshift >= {1'b0, dvs_r});

  // digit-by-digit root step, two radicand bits per cycle
  assign rshift = {srem_r, quo_r[X_W-1 -: 2]};
  assign rtrial = {1'b0, root_r, 2'b01};
  assign rdiff  = rshift - rtrial;
  assign rge    = (rshift >= rtrial);

  assign qv      = quo_r[PROD_W-1:0];
  assign acc_sum = ACC_W'(sum_r) + ACC_W'(sq_r);
  assign ovf     = (acc_sum > ACC_W'(SUM_MAX));
  assign last    = (cnt_r == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      L_IDLE: begin
        if (cmd.start) begin
          state_nxt = cmd.finish ? L_FDIV : L_MUL;
        end
      end
      L_MUL:  state_nxt = L_DIV;
      L_DIV:  if (last) state_nxt = L_SQR;
      L_SQR:  state_nxt = L_ACC;
      L_ACC:  state_nxt = L_DONE;
      L_FDIV: if (last) state_nxt = L_ROOT;
      L_ROOT: if (last) state_nxt = L_DONE;
      L_DONE: state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state_r == L_DONE);
    rsp.sat  = sat_rep_r;
    rsp.rms  = RMS_W'(root_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      sum_r   <= '0;
      sat_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == L_IDLE && cmd.start && cmd.finish) begin
        sum_r <= '0;
        sat_r <= 1'b0;
      end else if (state_r == L_ACC) begin
        sum_r <= ovf ? SUM_MAX : acc_sum[SUM_W-1:0];
        if (ovf) begin
          sat_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      L_IDLE: begin
        if (cmd.start) begin
          if (cmd.finish) begin
            quo_r     <= X_W'(sum_r);
            rem_r     <= '0;
            dvs_r     <= mdiv_eff;
            cnt_r     <= CNT_W'(X_W - 1);
            sat_rep_r <= sat_r;
          end else begin
            prod_r <= PROD_W'(sample) * PROD_W'(mult);
            dvs_r  <= MDIV_W'(sdiv_eff);
          end
        end
      end
      L_MUL: begin
        quo_r <= X_W'(prod_r) << (X_W - PROD_W);
        rem_r <= '0;
        cnt_r <= CNT_W'(PROD_W - 1);
      end
      L_DIV, L_FDIV: begin
        rem_r <= dge ? ddiff[MDIV_W-1:0] : dshift[MDIV_W-1:0];
        quo_r <= {quo_r[X_W-2:0], dge};
        if (last) begin
          cnt_r  <= CNT_W'(ROOT_W - 1);
          srem_r <= '0;
          root_r <= '0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
      L_SQR: begin
        sq_r <= SQ_W'(qv) * SQ_W'(qv);
      end
      L_ROOT: begin
        srem_r <= rge ? rdiff[ROOT_W:0] : rshift[ROOT_W:0];
        root_r <= {root_r[ROOT_W-2:0], rge};
        quo_r  <= quo_r << 2;
        cnt_r  <= cnt_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/trm_merge.sv
// Merge stage: combines both lanes' roots and saturation flags into one
// result word and holds it in the output register. Depends on trm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trm_merge (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       load,
  input  trm_pkg::lane_rsp_t        rsp_c,
  input  trm_pkg::lane_rsp_t        rsp_v,
  output logic                      free,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic [trm_pkg::RMS_W-1:0] out_current_rms,
  output logic [trm_pkg::RMS_W-1:0] out_voltage_rms,
  output logic                      out_saturated
);
  import trm_pkg::*;

  logic             valid_r;
  logic [RMS_W-1:0] cur_r;
  logic [RMS_W-1:0] vlt_r;
  logic             sat_r;

  assign free            = !valid_r || !out_stall;
  assign out_valid       = valid_r;
  assign out_current_rms = cur_r;
  assign out_voltage_rms = vlt_r;
  assign out_saturated   = sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= rsp_c.rms;
      vlt_r <= rsp_v.rms;
      sat_r <= rsp_c.sat | rsp_v.sat;
    end
  end

endmodule

`default_nettype wire

// File: hdl/two_channel_rms_meter.sv
// Top level of the two-channel RMS meter: configuration registers, the
// item sequencer, two trm_lane instances and the trm_merge output stage.
// Depends on trm_pkg, trm_lane and trm_merge.
//
// Usage:
//   Input words carry an action bit and one current and one voltage
//   reading. Action 0 adds the scaled squares to the running sums; action 1
//   closes the window and returns one result word with both RMS values and
//   the saturation flag, then clears the sums.
//   The configuration channel writes registers 0..4 (multipliers, dividers,
//   mean divisor); cfg_ready is always high, unknown indexes are dropped.
//   Both lanes run in lockstep, one item at a time.
//   Sample word: the next word is taken only after the 22-step divide of
//   the scaled reading.
//   Finish word: the result is loaded after the 48-step divide by the mean
//   divisor and the 24-step square root.
//   The output register holds a result while the receiver stalls; a later
//   item is still taken, and a finish waits only to load its own result.
//   Reset (rst_n low, synchronous) clears the sums, the flag, the output
//   valid and restores the default register values.
`timescale 1ns / 1ps
`default_nettype none

module two_channel_rms_meter (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire                            in_action,
  input  wire [trm_pkg::SAMPLE_W-1:0]    in_current_sample,
  input  wire [trm_pkg::SAMPLE_W-1:0]    in_voltage_sample,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [trm_pkg::RMS_W-1:0]      out_current_rms,
  output logic [trm_pkg::RMS_W-1:0]      out_voltage_rms,
  output logic                           out_saturated,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [trm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [trm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import trm_pkg::*;

  logic [MULT_W-1:0] cur_mult_r;
  logic [SDIV_W-1:0] cur_div_r;
  logic [MULT_W-1:0] vlt_mult_r;
  logic [SDIV_W-1:0] vlt_div_r;
  logic [MDIV_W-1:0] mean_div_r;

  top_state_t state_r, state_nxt;
  logic       fin_r;
  lane_cmd_t  cmd;
  lane_rsp_t  rsp_c;
  lane_rsp_t  rsp_v;
  logic       done;
  logic       free;
  logic       load;

  assign cfg_ready = 1'b1;
  assign done      = rsp_c.done & rsp_v.done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_mult_r <= MULT_W'(10);
      cur_div_r  <= SDIV_W'(12);
      vlt_mult_r <= MULT_W'(100);
      vlt_div_r  <= SDIV_W'(165);
      mean_div_r <= MDIV_W'(5000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CUR_MULT: cur_mult_r <= cfg_data[MULT_W-1:0];
        REG_CUR_DIV:  cur_div_r  <= cfg_data[SDIV_W-1:0];
        REG_VLT_MULT: vlt_mult_r <= cfg_data[MULT_W-1:0];
        REG_VLT_DIV:  vlt_div_r  <= cfg_data[SDIV_W-1:0];
        REG_MEAN_DIV: mean_div_r <= cfg_data[MDIV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE: if (in_valid) state_nxt = T_RUN;
      T_RUN: begin
        if (done) begin
          if (!fin_r || free) begin
            state_nxt = T_IDLE;
          end else begin
            state_nxt = T_HOLD;
          end
        end
      end
      T_HOLD: if (free) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state_r != T_IDLE);
    cmd.start  = (state_r == T_IDLE) && in_valid;
    cmd.finish = in_action;
    load       = ((state_r == T_RUN) && done && fin_r && free) ||
                 ((state_r == T_HOLD) && free);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.start) begin
        fin_r <= in_action;
      end
    end
  end

  trm_lane u_lane_cur (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sample (in_current_sample),
    .mult   (cur_mult_r),
    .sdiv   (cur_div_r),
    .mdiv   (mean_div_r),
    .rsp    (rsp_c)
  );

  trm_lane u_lane_vlt (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sample (in_voltage_sample),
    .mult   (vlt_mult_r),
    .sdiv   (vlt_div_r),
    .mdiv   (mean_div_r),
    .rsp    (rsp_v)
  );

  trm_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .rsp_c           (rsp_c),
    .rsp_v           (rsp_v),
    .free            (free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_current_rms (out_current_rms),
    .out_voltage_rms (out_voltage_rms),
    .out_saturated   (out_saturated)
  );

endmodule

`default_nettype wire

// File: hdl/trm_checker.sv
// Port-level checker for two_channel_rms_meter, attached by bind.
// Depends on trm_pkg and the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module trm_checker (
  input wire                       clk,
  input wire                       rst_n,
  input wire                       in_valid,
  input wire                       in_stall,
  input wire                       out_valid,
  input wire                       out_stall,
  input wire [trm_pkg::RMS_W-1:0]  out_current_rms,
  input wire [trm_pkg::RMS_W-1:0]  out_voltage_rms,
  input wire                       out_saturated
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_current_rms) &&
      $stable(out_voltage_rms) && $stable(out_saturated))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous word still in work");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared one cycle after accept");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset left block busy or output valid");

endmodule

bind two_channel_rms_meter trm_checker u_trm_checker (.*);

`default_nettype wire

// File: bench/two_channel_rms_meter_tb.sv
// Self-checking bench for the two-channel RMS meter: drives sample and finish words,
// rewrites the scaling registers between phases and checks every result word.
// Depends on trm_pkg and two_channel_rms_meter.
`timescale 1ns / 1ps

module two_channel_rms_meter_tb;
  import trm_pkg::*;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_FINISH = 1'b1;
  localparam logic [63:0] SUM_CAP = 64'(SUM_MAX);
  localparam int SAMPLE_TOP = (1 << SAMPLE_W) - 1;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic                act;
    logic [SAMPLE_W-1:0] cur;
    logic [SAMPLE_W-1:0] vlt;
  } meter_word_t;

  typedef struct {
    logic [RMS_W-1:0] cur;
    logic [RMS_W-1:0] vlt;
    logic             sat;
  } rms_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_action = ACT_SAMPLE;
  logic [SAMPLE_W-1:0]   in_current_sample = '0;
  logic [SAMPLE_W-1:0]   in_voltage_sample = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  wire                   in_stall;
  wire                   out_valid;
  wire [RMS_W-1:0]       out_current_rms;
  wire [RMS_W-1:0]       out_voltage_rms;
  wire                   out_saturated;
  wire                   cfg_ready;

  two_channel_rms_meter uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_current_sample (in_current_sample),
    .in_voltage_sample (in_voltage_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_current_rms   (out_current_rms),
    .out_voltage_rms   (out_voltage_rms),
    .out_saturated     (out_saturated),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #4 clk = ~clk;

  logic [MULT_W-1:0] cur_mult_q = 10;
  logic [SDIV_W-1:0] cur_div_q  = 12;
  logic [MULT_W-1:0] vlt_mult_q = 100;
  logic [SDIV_W-1:0] vlt_div_q  = 165;
  logic [MDIV_W-1:0] mean_div_q = 5000;
  logic [63:0]       cur_sum = '0;
  logic [63:0]       vlt_sum = '0;
  logic              window_sat = 1'b0;

  meter_word_t pending[$];
  rms_word_t   rms_due[$];
  meter_word_t nxt;
  rms_word_t   got;
  rms_word_t   want;

  int errors = 0;
  int words_queued = 0;
  int words_in = 0;
  int finishes_in = 0;
  int results_seen = 0;
  int sat_seen = 0;
  int settings = 1;
  int send_gap = 0;
  int rx_wait = 0;
  int rx_hold = 0;
  bit send_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;

  function automatic int pause_len(input bit quiet);
    if (quiet || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [63:0] scaled_square(input logic [SAMPLE_W-1:0] s,
                                                input logic [MULT_W-1:0] m,
                                                input logic [SDIV_W-1:0] d);
    logic [63:0] q;
    q = (64'(s) * 64'(m)) / ((d == '0) ? 64'd1 : 64'(d));
    return q * q;
  endfunction

  function automatic logic [RMS_W-1:0] floor_root(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = RMS_W - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r[RMS_W-1:0];
  endfunction

  task automatic add_square(inout logic [63:0] acc, input logic [63:0] sq);
    if (sq > SUM_CAP || acc > SUM_CAP - sq) begin
      acc = SUM_CAP;
      window_sat = 1'b1;
    end else begin
      acc = acc + sq;
    end
  endtask

  task automatic absorb_sample(input logic [SAMPLE_W-1:0] c, input logic [SAMPLE_W-1:0] v);
    add_square(cur_sum, scaled_square(c, cur_mult_q, cur_div_q));
    add_square(vlt_sum, scaled_square(v, vlt_mult_q, vlt_div_q));
  endtask

  task automatic close_window();
    logic [63:0] d;
    rms_word_t w;
    d = (mean_div_q == '0) ? 64'd1 : 64'(mean_div_q);
    w.cur = floor_root(cur_sum / d);
    w.vlt = floor_root(vlt_sum / d);
    w.sat = window_sat;
    rms_due.push_back(w);
    cur_sum = '0;
    vlt_sum = '0;
    window_sat = 1'b0;
    finishes_in++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (in_action == ACT_FINISH) close_window();
        else absorb_sample(in_current_sample, in_voltage_sample);
        words_in++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0 || pending.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid <= 1'b0;
        end else begin
          nxt = pending.pop_front();
          in_valid <= 1'b1;
          in_action <= nxt.act;
          in_current_sample <= nxt.cur;
          in_voltage_sample <= nxt.vlt;
          send_gap = pause_len(send_quiet);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
      rx_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.cur = out_current_rms;
        got.vlt = out_voltage_rms;
        got.sat = out_saturated;
        results_seen++;
        if (rms_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result word with none expected: cur %0d vlt %0d sat %0b",
                     $time, got.cur, got.vlt, got.sat);
        end else begin
          want = rms_due.pop_front();
          if (want.sat) sat_seen++;
          if (got.cur !== want.cur || got.vlt !== want.vlt || got.sat !== want.sat) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: expected cur %0d vlt %0d sat %0b, got cur %0d vlt %0d sat %0b",
                       $time, want.cur, want.vlt, want.sat, got.cur, got.vlt, got.sat);
          end
        end
        rx_wait = pause_len(rx_quiet);
      end
      if (hold_armed && !hold_done) begin
        rx_hold = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CUR_MULT: cur_mult_q = data[MULT_W-1:0];
      REG_CUR_DIV:  cur_div_q  = data[SDIV_W-1:0];
      REG_VLT_MULT: vlt_mult_q = data[MULT_W-1:0];
      REG_VLT_DIV:  vlt_div_q  = data[SDIV_W-1:0];
      REG_MEAN_DIV: mean_div_q = data[MDIV_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_reg(input int width);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 1;
      2: return CFG_DATA_W'((1 << width) - 1);
      3: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(1, (1 << width) - 1));
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return SAMPLE_W'(SAMPLE_TOP);
      default: return SAMPLE_W'($urandom_range(0, SAMPLE_TOP));
    endcase
  endfunction

  task automatic queue_word(input logic act, input int c, input int v);
    meter_word_t w;
    w.act = act;
    w.cur = SAMPLE_W'(c);
    w.vlt = SAMPLE_W'(v);
    pending.push_back(w);
    words_queued++;
  endtask

  task automatic queue_window(input int len);
    for (int i = 0; i < len; i++) queue_word(ACT_SAMPLE, pick_sample(), pick_sample());
    queue_word(ACT_FINISH, pick_sample(), pick_sample());
  endtask

  task automatic settle();
    do @(posedge clk); while (pending.size() != 0 || in_valid || rms_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int len;
    int phase_words;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    queue_word(ACT_SAMPLE, 0, 0);
    queue_word(ACT_SAMPLE, SAMPLE_TOP, SAMPLE_TOP);
    queue_word(ACT_SAMPLE, 2048, 1);
    queue_word(ACT_FINISH, SAMPLE_TOP, SAMPLE_TOP);
    queue_word(ACT_FINISH, 0, 0);
    settle();

    write_reg(REG_CUR_MULT, 1000);
    write_reg(REG_CUR_DIV, 1);
    write_reg(REG_VLT_MULT, 16'hFFFF);
    write_reg(REG_VLT_DIV, 0);
    write_reg(REG_MEAN_DIV, 0);
    write_reg(3'd5, 16'h1234);
    write_reg(3'd7, 16'hFFFF);
    settings++;
    repeat (18) queue_word(ACT_SAMPLE, SAMPLE_TOP, SAMPLE_TOP);
    queue_word(ACT_FINISH, 0, 0);
    settle();

    write_reg(REG_CUR_MULT, 0);
    write_reg(REG_VLT_DIV, 255);
    settings++;
    queue_word(ACT_SAMPLE, SAMPLE_TOP, SAMPLE_TOP);
    queue_word(ACT_FINISH, 0, 0);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        write_reg(REG_CUR_MULT, 16'hFFFF);
        write_reg(REG_CUR_DIV, 16'hFFFF);
        write_reg(REG_VLT_MULT, 16'hFFFF);
        write_reg(REG_VLT_DIV, 16'hFFFF);
        write_reg(REG_MEAN_DIV, 16'hFFFF);
      end else if (ph == 1) begin
        write_reg(REG_CUR_MULT, 1023);
        write_reg(REG_CUR_DIV, 1);
        write_reg(REG_VLT_MULT, 1023);
        write_reg(REG_VLT_DIV, 1);
        write_reg(REG_MEAN_DIV, 1);
      end else begin
        write_reg(REG_CUR_MULT, pick_reg(MULT_W));
        write_reg(REG_CUR_DIV, pick_reg(SDIV_W));
        write_reg(REG_VLT_MULT, pick_reg(MULT_W));
        write_reg(REG_VLT_DIV, pick_reg(SDIV_W));
        write_reg(REG_MEAN_DIV, pick_reg(MDIV_W));
        if ($urandom_range(0, 2) == 0)
          write_reg(CFG_IDX_W'($urandom_range(5, 7)), CFG_DATA_W'($urandom));
      end
      settings++;
      send_quiet = (ph % 3 == 2);
      rx_quiet = (ph % 4 == 1);
      if (ph == 3) hold_armed = 1'b1;
      phase_words = 0;
      while (phase_words < 62) begin
        case ($urandom_range(0, 9))
          0: len = 0;
          1: len = $urandom_range(15, 40);
          default: len = $urandom_range(1, 8);
        endcase
        queue_window(len);
        phase_words += len + 1;
      end
      settle();
    end

    errors += rms_due.size();
    $display("Covered %0d input words (%0d finishes) under %0d register settings;",
             words_in, finishes_in, settings);
    $display("checked %0d result words, %0d of them with a saturated window.",
             results_seen, sat_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timeout with %0d result words still expected", rms_due.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
